/* rtl/sptd_pkg.sv */
// ----------------------------------------------------------------------------
// sptd_pkg
// Shared types and constants of the sensor packet table decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sptd_pkg;

   localparam int SensorEntriesDef  = 8;
   localparam int SlotsPerSensorDef = 8;

   // packet fields
   localparam int WordWidth   = 32;
   localparam int TimeWidth   = 32;
   localparam int IdWidth     = 8;
   localparam int SlotWidth   = 4;
   localparam int ValueWidth  = 16;
   localparam int StatusWidth = 3;
   localparam int IndexWidth  = 4;
   localparam int NibbleMask  = 'hf;

   // stream widths, packed and padded to whole bytes
   localparam int ReqDataWidth = 64;
   localparam int RspFieldBits = StatusWidth + IndexWidth + IdWidth + SlotWidth;
   localparam int RspDataWidth = ((RspFieldBits + 7) / 8) * 8;
   localparam int RspPadWidth  = RspDataWidth - RspFieldBits;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_STORED = 3'd0,
      STATUS_LAST   = 3'd1,
      STATUS_BADSUM = 3'd2,
      STATUS_FULL   = 3'd3,
      STATUS_SLOT   = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the request
      logic check;   // checksum and id compare
      logic update;  // table update and result load
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // result register can take a new result
   } stat_type;

endpackage : sptd_pkg

`default_nettype wire

/* rtl/sptd_ctrl.sv */
// ----------------------------------------------------------------------------
// sptd_ctrl
// Sequencer: accept, check, update; one request in flight at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sptd_ctrl
   import sptd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CHECK  = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the result register frees up
            if (stat.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : sptd_ctrl

`default_nettype wire

/* rtl/sptd_dpath.sv */
// ----------------------------------------------------------------------------
// sptd_dpath
// Request registers, sensor table, slot store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sptd_dpath
   import sptd_pkg::*;
#(
   parameter int SENSOR_ENTRIES   = SensorEntriesDef,
   parameter int SLOTS_PER_SENSOR = SlotsPerSensorDef
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataWidth-1:0]      rsp_tdata
);

   localparam int UW = $clog2(SENSOR_ENTRIES + 1);
   localparam int IW = (SENSOR_ENTRIES > 1) ? $clog2(SENSOR_ENTRIES) : 1;
   localparam int Depth = SENSOR_ENTRIES * SLOTS_PER_SENSOR;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   // request
   logic [WordWidth-1:0] word_ff;
   logic [TimeWidth-1:0] time_ff;
   logic                 sum_ok_ff;
   logic [SENSOR_ENTRIES-1:0] match_ff;

   // table
   logic [UW-1:0]          used_ff;
   logic [IdWidth-1:0]     entry_id_ff   [SENSOR_ENTRIES];
   logic [TimeWidth-1:0]   entry_time_ff [SENSOR_ENTRIES];
   logic [SENSOR_ENTRIES-1:0] enabled_ff;
   logic [SLOTS_PER_SENSOR-1:0] slot_valid_ff [SENSOR_ENTRIES];
   logic [ValueWidth-1:0]  slot_mem [Depth];

   // result
   logic                  rsp_valid_ff;
   status_type            status_ff;
   logic [IndexWidth-1:0] index_ff;
   logic [IdWidth-1:0]    id_ff;
   logic [SlotWidth-1:0]  slot_ff;

   logic [IdWidth-1:0]    pkt_id;
   logic [SlotWidth-1:0]  pkt_slot;
   logic [ValueWidth-1:0] pkt_value;
   logic [SlotWidth-1:0]  nib_sum;
   logic [SENSOR_ENTRIES-1:0] match;
   logic                  found;
   logic [IW-1:0]         enc;
   logic                  room;
   logic                  create;
   logic                  hit;
   logic [IW-1:0]         idx;
   logic                  slot_ok;
   logic                  store;
   logic [SLOTS_PER_SENSOR-1:0] slot_bit;
   status_type            status_in;
   logic [AW-1:0]         addr;

   assign pkt_id    = word_ff[31:24];
   assign pkt_slot  = word_ff[23:20];
   assign pkt_value = word_ff[ValueWidth-1:0];

   // checksum over the captured request word
   always_comb begin
      nib_sum = '0;
      for (int k = 0; k < 8; k++) begin
         if (k != 4) begin
            nib_sum = nib_sum + SlotWidth'((word_ff >> (4 * k)) & NibbleMask);
         end
      end
   end

   // id compare against entries in use
   always_comb begin
      for (int i = 0; i < SENSOR_ENTRIES; i++) begin
         match[i] = (UW'(i) < used_ff) && (entry_id_ff[i] == pkt_id);
      end
   end

   // first matching entry
   always_comb begin
      found = 1'b0;
      enc   = '0;
      for (int i = SENSOR_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            found = 1'b1;
            enc   = IW'(i);
         end
      end
   end

   always_comb begin
      room    = (used_ff != UW'(SENSOR_ENTRIES));
      create  = sum_ok_ff && !found && room;
      hit     = sum_ok_ff && (found || room);
      idx     = found ? enc : used_ff[IW-1:0];
      slot_ok = ({1'b0, pkt_slot} < 5'(SLOTS_PER_SENSOR));
      store   = hit && slot_ok;
      slot_bit = store ? (SLOTS_PER_SENSOR'(1) << pkt_slot) : '0;
      if (!sum_ok_ff) begin
         status_in = STATUS_BADSUM;
      end else if (!hit) begin
         status_in = STATUS_FULL;
      end else if (!slot_ok) begin
         status_in = STATUS_SLOT;
      end else if (pkt_slot == SlotWidth'(SLOTS_PER_SENSOR - 1)) begin
         status_in = STATUS_LAST;
      end else begin
         status_in = STATUS_STORED;
      end
      addr = AW'(int'(idx) * SLOTS_PER_SENSOR + int'(pkt_slot));
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // request capture and compare stage
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_tdata[WordWidth-1:0];
         time_ff <= req_tdata[WordWidth +: TimeWidth];
      end
      if (cmd.check) begin
         sum_ok_ff <= (nib_sum == word_ff[19:16]);
         match_ff  <= match;
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.update && create) begin
         used_ff <= used_ff + UW'(1);
      end
   end

   // table entries: a store wins over the clear of a fresh entry
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (create) begin
            entry_id_ff[idx]   <= pkt_id;
            slot_valid_ff[idx] <= slot_bit;
         end else if (store) begin
            slot_valid_ff[idx] <= slot_valid_ff[idx] | slot_bit;
         end
         if (store) begin
            entry_time_ff[idx] <= time_ff;
            enabled_ff[idx]    <= 1'b1;
         end else if (create) begin
            entry_time_ff[idx] <= '0;
            enabled_ff[idx]    <= 1'b0;
         end
      end
   end

   // slot value store
   always_ff @(posedge clock) begin
      if (cmd.update && store) begin
         slot_mem[addr] <= pkt_value;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         status_ff <= status_in;
         index_ff  <= hit ? IndexWidth'(idx) : '0;
         id_ff     <= pkt_id;
         slot_ff   <= pkt_slot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RspPadWidth{1'b0}}, slot_ff, id_ff, index_ff, status_ff};

endmodule : sptd_dpath

`default_nettype wire

/* rtl/sensor_packet_table_decoder_core.sv */
// ----------------------------------------------------------------------------
// sensor_packet_table_decoder_core
// Checks a radio sensor word, finds or appends its sensor entry and stores
// the slot value; returns a status and the entry index per request.
// ----------------------------------------------------------------------------
// rsp_tvalid rises from the result register once the accepted request has passed the check
//   and update states. Each request passes in turn through accept, checksum and id compare,
//   and table update; the controller keeps one request in flight.
// A waiting result does not block the next request; only the update of the
//   following one waits for the result register to drain.
// Reset (synchronous, active high) empties the table and drops any result.
`default_nettype none

module sensor_packet_table_decoder_core
   import sptd_pkg::*;
#(
   parameter int SENSOR_ENTRIES   = SensorEntriesDef,
   parameter int SLOTS_PER_SENSOR = SlotsPerSensorDef
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [ReqDataWidth-1:0] req_tdata,   // packet_word[31:0], arrival_time[63:32]
   // result channel
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataWidth-1:0]      rsp_tdata    // status[2:0], entry_index[6:3],
                                                     // sensor_id[14:7], slot_number[18:15]
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decides when to capture, compare and commit
   sptd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: sensor table, slot store and result register
   sptd_dpath #(
      .SENSOR_ENTRIES   (SENSOR_ENTRIES),
      .SLOTS_PER_SENSOR (SLOTS_PER_SENSOR)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule : sensor_packet_table_decoder_core

`default_nettype wire

/* verif/sptd_decode_checker.sv */
// ----------------------------------------------------------------------------
// sptd_decode_checker
// Watches the request and result streams of the sensor packet table decoder,
// predicts each result from its own copy of the sensor table and compares
// the results field by field in arrival order.
// ----------------------------------------------------------------------------

module sptd_decode_checker
   import sptd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,
   output int                      fail_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Entries    = SensorEntriesDef;
   localparam int Slots      = SlotsPerSensorDef;
   localparam int MaxReports = 10;
   localparam int IndexLsb   = StatusWidth;
   localparam int IdLsb      = IndexLsb + IndexWidth;
   localparam int SlotLsb    = IdLsb + IdWidth;
   localparam int PadLsb     = SlotLsb + SlotWidth;

   typedef struct {
      status_type             status;
      logic [IndexWidth-1:0]  index;
      logic [IdWidth-1:0]     id;
      logic [SlotWidth-1:0]   slot;
      logic [RspPadWidth-1:0] pad;
   } decode_result_type;

   // sensor table as the block should hold it
   logic [IdWidth-1:0]    sensor_id_tab  [Entries];
   logic [TimeWidth-1:0]  sensor_stamp   [Entries];
   logic                  sensor_enabled [Entries];
   logic [ValueWidth-1:0] slot_reading   [Entries][Slots];
   logic                  slot_filled    [Entries][Slots];
   int                    sensors_in_use = 0;

   decode_result_type pending_decodes[$];
   int                mismatch_total = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Decode one packet against the table and apply its update.
   function automatic decode_result_type decode_packet(input logic [WordWidth-1:0] word,
                                                       input logic [TimeWidth-1:0] stamp);
      decode_result_type res;
      logic [3:0]        nib_sum;
      int                hit;
      int                k;
      res.id     = word[31:24];
      res.slot   = word[23:20];
      res.index  = '0;
      res.pad    = '0;
      res.status = STATUS_BADSUM;
      nib_sum    = '0;
      for (k = 0; k < 8; k++) begin
         if (k != 4) nib_sum += word[4*k +: 4];
      end
      if (nib_sum == word[19:16]) begin
         hit = -1;
         for (k = 0; k < sensors_in_use; k++) begin
            if (hit < 0 && sensor_id_tab[k] == res.id) hit = k;
         end
         // append an unknown sensor while there is room
         if (hit < 0 && sensors_in_use < Entries) begin
            hit                 = sensors_in_use;
            sensor_id_tab[hit]  = res.id;
            sensor_stamp[hit]   = '0;
            sensor_enabled[hit] = 1'b0;
            for (k = 0; k < Slots; k++) slot_filled[hit][k] = 1'b0;
            sensors_in_use++;
         end
         if (hit < 0) begin
            res.status = STATUS_FULL;
         end else begin
            res.index = IndexWidth'(hit);
            if (res.slot >= Slots) begin
               // entry made above stays, nothing is stored
               res.status = STATUS_SLOT;
            end else begin
               sensor_stamp[hit]             = stamp;
               slot_reading[hit][res.slot]   = word[ValueWidth-1:0];
               slot_filled[hit][res.slot]    = 1'b1;
               sensor_enabled[hit]           = 1'b1;
               res.status = (res.slot == Slots - 1) ? STATUS_LAST : STATUS_STORED;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      decode_result_type seen;
      decode_result_type want;
      if (reset) begin
         sensors_in_use = 0;
         pending_decodes.delete();
         mismatch_total = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_decodes.push_back(decode_packet(req_tdata[WordWidth-1:0],
                                                    req_tdata[WordWidth +: TimeWidth]));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.status = status_type'(rsp_tdata[StatusWidth-1:0]);
            seen.index  = rsp_tdata[IndexLsb +: IndexWidth];
            seen.id     = rsp_tdata[IdLsb +: IdWidth];
            seen.slot   = rsp_tdata[SlotLsb +: SlotWidth];
            seen.pad    = rsp_tdata[PadLsb +: RspPadWidth];
            if (pending_decodes.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= MaxReports)
                  $display("%0t: result with no request: status=%0d index=%0d id=%02h slot=%0d",
                           $realtime, seen.status, seen.index, seen.id, seen.slot);
            end else begin
               want = pending_decodes.pop_front();
               if (seen.status !== want.status || seen.index !== want.index ||
                   seen.id !== want.id || seen.slot !== want.slot || seen.pad !== want.pad) begin
                  mismatch_total++;
                  if (mismatch_total <= MaxReports) begin
                     $display("%0t: decode result differs: expected status=%0d index=%0d",
                              $realtime, want.status, want.index);
                     $display("   expected id=%02h slot=%0d pad=%0h",
                              want.id, want.slot, want.pad);
                     $display("   got status=%0d index=%0d id=%02h slot=%0d pad=%0h",
                              seen.status, seen.index, seen.id, seen.slot, seen.pad);
                  end
               end
            end
         end
      end
      fail_count    <= mismatch_total;
      pending_count <= pending_decodes.size();
   end

endmodule : sptd_decode_checker

/* verif/tb_sensor_packet_table_decoder_core.sv */
// ----------------------------------------------------------------------------
// tb_sensor_packet_table_decoder_core
// Drives sensor packets into the decoder: a directed pass that fills the
// sensor table and hits every status, then random packets with random idle
// gaps and result stalls. The checker beside the block scores each result.
// ----------------------------------------------------------------------------

module tb_sensor_packet_table_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import sptd_pkg::*;

   localparam int StallLimit    = 2000;  // cycles without any accepted transfer
   localparam int DrainCycles   = 20;    // quiet time after the last result
   localparam int RandomPackets = 1430;
   localparam int ModeRun       = 64;    // items per idle-mode draw

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   int   fail_count;
   int   pending_count;
   int   idle_cycles = 0;
   logic send_burst  = 1'b0;
   logic take_burst  = 1'b0;
   int   take_hold   = 0;
   int   taken       = 0;

   // Ids the random part aims at; the directed part puts all of them in the table.
   logic [IdWidth-1:0] sensor_pool [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5,
                                          8'h01, 8'h80, 8'h7E, 8'h3C};

   sensor_packet_table_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sptd_decode_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Build a packet word; a bad checksum flips at least one checksum bit.
   function automatic logic [WordWidth-1:0] make_packet(input logic [IdWidth-1:0]    id,
                                                        input logic [SlotWidth-1:0]  slot,
                                                        input logic [ValueWidth-1:0] value,
                                                        input logic                  good_sum);
      logic [WordWidth-1:0] word;
      logic [3:0]           nib_sum;
      int                   k;
      word    = {id, slot, 4'h0, value};
      nib_sum = '0;
      for (k = 0; k < 8; k++) nib_sum += word[4*k +: 4];
      if (!good_sum) nib_sum ^= 4'($urandom_range(1, 15));
      word[19:16] = nib_sum;
      return word;
   endfunction

   // Idle cycles before the next transfer; a burst mode idles never.
   function automatic int draw_gap(input logic burst);
      return burst ? 0 : int'($urandom_range(0, 19));
   endfunction

   // Send one request. Enter and leave at a falling edge.
   task automatic push_packet(input logic [WordWidth-1:0] word,
                              input logic [TimeWidth-1:0] stamp);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         // drop valid and scramble the bus while idle
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, word};
      // hold the request until the block takes it
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Result side: after each accepted result, stall for a drawn number of cycles.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            taken++;
            if (taken % ModeRun == 0) take_burst = ($urandom_range(0, 3) == 0);
            take_hold = draw_gap(take_burst);
         end
         @(negedge clock);
         if (take_hold > 0) begin
            rsp_tready <= 1'b0;
            take_hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                   n;
      int                   pick;
      logic [SlotWidth-1:0] slot;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pass: fill the table in a known order and reach every status.
      // new sensor, first slot, all-zero value and time
      push_packet(make_packet(8'h00, 4'd0, 16'h0000, 1'b1), 32'h0000_0000);
      // new sensor, last slot, all-ones value and time
      push_packet(make_packet(8'hFF, 4'd7, 16'hFFFF, 1'b1), 32'hFFFF_FFFF);
      // known sensor, last slot
      push_packet(make_packet(8'h00, 4'd7, 16'h8000, 1'b1), 32'h0000_0001);
      // new sensor with a slot out of range: the entry stays
      push_packet(make_packet(8'h5A, 4'd8, 16'h1234, 1'b1), 32'h1234_5678);
      push_packet(make_packet(8'h5A, 4'd15, 16'hFFFF, 1'b1), 32'h8000_0000);
      push_packet(make_packet(8'h5A, 4'd3, 16'h5555, 1'b1), 32'hAAAA_5555);
      // bad checksum on an unknown sensor: no entry made
      push_packet(make_packet(8'hA5, 4'd2, 16'hAAAA, 1'b0), 32'h5555_AAAA);
      push_packet(32'hFFFF_FFFF, 32'h0000_0000);
      // all-zero word carries a valid checksum
      push_packet(32'h0000_0000, 32'hFFFF_FFFF);
      // fill the remaining entries
      push_packet(make_packet(8'hA5, 4'd1, 16'h0F0F, 1'b1), 32'h0000_00FF);
      push_packet(make_packet(8'h01, 4'd6, 16'hF0F0, 1'b1), 32'h00FF_0000);
      push_packet(make_packet(8'h80, 4'd9, 16'h00FF, 1'b1), 32'hFF00_0000);
      push_packet(make_packet(8'h7E, 4'd0, 16'hFF00, 1'b1), 32'h7FFF_FFFF);
      push_packet(make_packet(8'h3C, 4'd7, 16'h7FFF, 1'b1), 32'h0001_0000);
      // table full, in and out of slot range, and a bad checksum while full
      push_packet(make_packet(8'h42, 4'd2, 16'h4242, 1'b1), 32'h4242_4242);
      push_packet(make_packet(8'h42, 4'd12, 16'h0001, 1'b1), 32'h0000_4242);
      push_packet(make_packet(8'h42, 4'd5, 16'h0002, 1'b0), 32'h4200_0000);
      // store into the entry made by an out-of-range slot
      push_packet(make_packet(8'h80, 4'd5, 16'hBEEF, 1'b1), 32'hDEAD_BEEF);
      push_packet(make_packet(8'hFF, 4'd0, 16'h0000, 1'b1), 32'hC0DE_0000);

      // Random pass: mostly known sensors, some unknown ids, some corrupt words.
      for (n = 0; n < RandomPackets; n++) begin
         if (n % ModeRun == 0) send_burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         slot = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                            : 4'($urandom_range(0, 7));
         if (pick < 75)
            push_packet(make_packet(sensor_pool[$urandom_range(0, 7)], slot,
                                    16'($urandom), 1'b1), $urandom);
         else if (pick < 87)
            push_packet(make_packet(8'($urandom), slot, 16'($urandom), 1'b1), $urandom);
         else
            push_packet(make_packet(8'($urandom), 4'($urandom), 16'($urandom), 1'b0),
                        $urandom);
      end
      req_tvalid <= 1'b0;

      // drain: wait for every predicted result, then let the block settle
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule : tb_sensor_packet_table_decoder_core
